### hw/rtl/echo_tank_level_relay_core_defines.svh
// Assertion helpers for the tank level relay. Every check is sampled on clk
// and switched off while rst is high.
`ifndef ECHO_TANK_LEVEL_RELAY_CORE_DEFINES_SVH
`define ECHO_TANK_LEVEL_RELAY_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/etl_pkg.sv
`timescale 1ns / 1ps

package etl_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  // shared adder width: largest operand is the 64-bit gallon sum plus rounding
  localparam int AluW = 65;

  // engine datapath widths
  localparam int QW    = 62;  // dividend / quotient / radicand
  localparam int RemW  = 34;  // divide and root remainder
  localparam int RootW = 31;  // speed-of-sound factor, Q24
  localparam int HiW   = 49;  // upper half of the shift-add product
  localparam int LoW   = 32;  // multiplier / lower half of the product
  localparam int CntW  = 6;

  localparam int StartDelayTicks = 4400;
  localparam int PercentScale    = 100;

  localparam int Div1Steps  = 62;
  localparam int SqrtSteps  = 31;
  localparam int Div2Steps  = 31;
  localparam int MulStepsM  = 24;
  localparam int MulStepsE  = 16;
  localparam int MulStepsG  = 32;
  localparam int MulStepsP  = 7;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENSOR_IS_DIGITAL = 3'd0,
    REG_MM_PER_TICK       = 3'd1,
    REG_ZERO_C_KELVIN     = 3'd2,
    REG_SENSOR_HEIGHT     = 3'd3,
    REG_GALLONS_PER_MM    = 3'd4,
    REG_MAX_HEIGHT        = 3'd5,
    REG_RELAY_ON          = 3'd6,
    REG_RELAY_OFF         = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        sensor_is_digital;
    logic [23:0] mm_per_tick_at_zero_c;
    logic [11:0] zero_c_kelvin_tenths;
    logic [15:0] sensor_height_mm;
    logic [31:0] gallons_per_mm;
    logic [15:0] max_height_mm;
    logic [6:0]  relay_on_percent;
    logic [6:0]  relay_off_percent;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        echo_ticks;
    logic signed [11:0] air_temp_tenths_c;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] empty_space_mm;
    logic signed [31:0] water_gallons;
    logic signed [15:0] percent_full;
    logic               relay_on;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV1,
    S_SQRT,
    S_LD_M,
    S_MUL_M,
    S_MUL_E,
    S_H1,
    S_H2,
    S_MUL_G,
    S_RND,
    S_MUL_P,
    S_DIV2,
    S_DONE
  } eng_state_e;

  typedef struct packed {
    logic idle;
    logic done;
    logic relay;
  } eng_status_t;

endpackage

### hw/rtl/etl_cfg_regs.sv
`timescale 1ns / 1ps

module etl_cfg_regs
  import etl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_is_digital     <= 1'b0;
      cfg.mm_per_tick_at_zero_c <= 24'd1389586;
      cfg.zero_c_kelvin_tenths  <= 12'd2732;
      cfg.sensor_height_mm      <= 16'd2000;
      cfg.gallons_per_mm        <= 32'd65536;
      cfg.max_height_mm         <= 16'd1000;
      cfg.relay_on_percent      <= 7'd80;
      cfg.relay_off_percent     <= 7'd20;
    end else if (wr_en) begin
      unique case (cfg_reg_e'(wr_index))
        REG_SENSOR_IS_DIGITAL: cfg.sensor_is_digital     <= wr_data[0];
        REG_MM_PER_TICK:       cfg.mm_per_tick_at_zero_c <= wr_data[23:0];
        REG_ZERO_C_KELVIN:     cfg.zero_c_kelvin_tenths  <= wr_data[11:0];
        REG_SENSOR_HEIGHT:     cfg.sensor_height_mm      <= wr_data[15:0];
        REG_GALLONS_PER_MM:    cfg.gallons_per_mm        <= wr_data;
        REG_MAX_HEIGHT:        cfg.max_height_mm         <= wr_data[15:0];
        REG_RELAY_ON:          cfg.relay_on_percent      <= wr_data[6:0];
        REG_RELAY_OFF:         cfg.relay_off_percent     <= wr_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/etl_alu.sv
`timescale 1ns / 1ps

// Shared adder. For subtract, carry high means a >= b (no borrow).
module etl_alu
  import etl_pkg::*;
(
  input  logic [AluW-1:0] a,
  input  logic [AluW-1:0] b,
  input  logic            sub,
  output logic [AluW-1:0] sum,
  output logic            carry
);

  logic [AluW-1:0] b_op;
  logic [AluW:0]   total;

  assign b_op  = sub ? ~b : b;
  assign total = {1'b0, a} + {1'b0, b_op} + {{AluW{1'b0}}, sub};
  assign sum   = total[AluW-1:0];
  assign carry = total[AluW];

endmodule

### hw/rtl/etl_engine.sv
`timescale 1ns / 1ps

module etl_engine
  import etl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  in_item_t    in_item,
  input  cfg_t        cfg,
  input  logic        res_take,
  output out_item_t   res_item,
  output eng_status_t status
);

  localparam logic [16:0]      DelayTicks = 17'(StartDelayTicks);
  localparam logic [RootW-1:0] FacOne     = RootW'(1) << 24;

  eng_state_e state, state_next;

  logic [QW-1:0]    q, q_next;
  logic [RemW-1:0]  rem, rem_next;
  logic [RootW-1:0] root, root_next;
  logic [HiW-1:0]   hi, hi_next;
  logic [LoW-1:0]   lo, lo_next;
  logic [CntW-1:0]  cnt, cnt_next;
  logic [RootW-1:0] fac, fac_next;
  logic [30:0]      mpt, mpt_next;
  logic [15:0]      tmag, tmag_next;
  logic             tneg, tneg_next;
  logic [46:0]      emag, emag_next;
  logic [47:0]      habs, habs_next;
  logic             hneg, hneg_next;
  logic [40:0]      gmag, gmag_next;
  logic             relay, relay_next;

  logic [AluW-1:0] alu_a, alu_b, alu_sum;
  logic            alu_sub, alu_co;

  logic [16:0]      ticks;
  logic [15:0]      tmag_in;
  logic [13:0]      num;
  logic             num_pos;
  logic [16:0]      div_t;
  logic [15:0]      div_d;
  logic [RemW-1:0]  sqrt_t;
  logic [RootW+1:0] sqrt_trial;
  logic [RootW-1:0] sqrt_root;
  logic [47:0]      mul_cand;
  logic [HiW-1:0]   mul_hi;
  logic [LoW-1:0]   mul_lo;

  logic [22:0]        emm_mag;
  logic [15:0]        emm_val;
  logic [31:0]        gal_val;
  logic [30:0]        pquo;
  logic signed [15:0] pct_val;
  logic               relay_new;

  etl_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_co)
  );

  // input preparation
  always_comb begin
    ticks   = {1'b0, in_item.echo_ticks} - (cfg.sensor_is_digital ? DelayTicks : 17'd0);
    tmag_in = ticks[16] ? 16'(17'd0 - ticks) : ticks[15:0];
    num     = {2'b00, cfg.zero_c_kelvin_tenths}
            + {{2{in_item.air_temp_tenths_c[11]}}, in_item.air_temp_tenths_c};
    num_pos = !num[13] && (num != '0);
  end

  // step operands
  always_comb begin
    div_t      = {rem[15:0], q[QW-1]};
    div_d      = (state == S_DIV1) ? {4'b0000, cfg.zero_c_kelvin_tenths} : cfg.max_height_mm;
    sqrt_t     = {rem[RemW-3:0], q[QW-1:QW-2]};
    sqrt_trial = {root, 2'b01};
    sqrt_root  = {root[RootW-2:0], alu_co};
    case (state) inside
      S_MUL_M:          mul_cand = 48'(fac);
      S_MUL_E:          mul_cand = 48'(mpt);
      S_MUL_G, S_MUL_P: mul_cand = habs;
      default:          mul_cand = '0;
    endcase
    mul_hi = alu_sum[HiW:1];
    mul_lo = {alu_sum[0], lo[LoW-1:1]};
  end

  // operand steering into the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state) inside
      S_DIV1, S_DIV2: begin
        alu_a   = AluW'(div_t);
        alu_b   = AluW'(div_d);
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        alu_a   = AluW'(sqrt_t);
        alu_b   = AluW'(sqrt_trial);
        alu_sub = 1'b1;
      end
      S_MUL_M, S_MUL_E, S_MUL_G, S_MUL_P: begin
        alu_a = AluW'(hi);
        alu_b = lo[0] ? AluW'(mul_cand) : '0;
      end
      S_H1: begin
        // sensor height minus a positive echo, plus a negative one
        alu_a   = AluW'({cfg.sensor_height_mm, 24'd0});
        alu_b   = AluW'(emag);
        alu_sub = !tneg;
      end
      S_H2: begin
        alu_a   = AluW'(emag);
        alu_b   = AluW'({cfg.sensor_height_mm, 24'd0});
        alu_sub = 1'b1;
      end
      S_RND: begin
        alu_a = AluW'({hi[47:0], lo[LoW-1:16]});
        alu_b = AluW'(1) << 23;
      end
      default: ;
    endcase
  end

  // result formatting and relay hysteresis
  always_comb begin
    emm_mag = emag[46:24];
    if (!tneg) begin
      emm_val = (emm_mag > 23'd32767) ? 16'h7FFF : emm_mag[15:0];
    end else begin
      emm_val = (emm_mag > 23'd32768) ? 16'h8000 : 16'(23'd0 - emm_mag);
    end

    if (!hneg) begin
      gal_val = (gmag > 41'h7FFF_FFFF) ? 32'h7FFF_FFFF : gmag[31:0];
    end else begin
      gal_val = (gmag > 41'h8000_0000) ? 32'h8000_0000 : 32'(41'd0 - gmag);
    end

    pquo = q[30:0];
    if (cfg.max_height_mm == '0) begin
      if (hneg) begin
        pct_val = 16'sh8000;
      end else begin
        pct_val = (habs != '0) ? 16'sh7FFF : 16'sh0000;
      end
    end else if (!hneg) begin
      pct_val = (pquo > 31'd32767) ? 16'sh7FFF : $signed(pquo[15:0]);
    end else begin
      pct_val = (pquo > 31'd32768) ? 16'sh8000 : $signed(16'(31'd0 - pquo));
    end

    if (relay) begin
      relay_new = !(pct_val < $signed({9'd0, cfg.relay_off_percent}));
    end else begin
      relay_new = pct_val > $signed({9'd0, cfg.relay_on_percent});
    end

    res_item.empty_space_mm = emm_val;
    res_item.water_gallons  = gal_val;
    res_item.percent_full   = pct_val;
    res_item.relay_on       = relay_new;
  end

  always_comb begin
    state_next = state;
    q_next     = q;
    rem_next   = rem;
    root_next  = root;
    hi_next    = hi;
    lo_next    = lo;
    cnt_next   = cnt;
    fac_next   = fac;
    mpt_next   = mpt;
    tmag_next  = tmag;
    tneg_next  = tneg;
    emag_next  = emag;
    habs_next  = habs;
    hneg_next  = hneg;
    gmag_next  = gmag;
    relay_next = relay;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          tneg_next = ticks[16];
          tmag_next = tmag_in;
          if (cfg.zero_c_kelvin_tenths == '0) begin
            fac_next   = FacOne;
            state_next = S_LD_M;
          end else if (!num_pos) begin
            // at or below absolute zero: no sound, no distance
            fac_next   = '0;
            state_next = S_LD_M;
          end else begin
            q_next     = {1'b0, num[12:0], 48'd0};
            rem_next   = '0;
            cnt_next   = CntW'(Div1Steps);
            state_next = S_DIV1;
          end
        end
      end
      S_DIV1, S_DIV2: begin
        rem_next = alu_co ? RemW'(alu_sum[16:0]) : RemW'(div_t);
        q_next   = {q[QW-2:0], alu_co};
        cnt_next = cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          if (state == S_DIV1) begin
            rem_next   = '0;
            root_next  = '0;
            cnt_next   = CntW'(SqrtSteps);
            state_next = S_SQRT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SQRT: begin
        rem_next  = alu_co ? alu_sum[RemW-1:0] : sqrt_t;
        root_next = sqrt_root;
        q_next    = {q[QW-3:0], 2'b00};
        cnt_next  = cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          fac_next   = sqrt_root;
          state_next = S_LD_M;
        end
      end
      S_LD_M: begin
        hi_next    = '0;
        lo_next    = LoW'(cfg.mm_per_tick_at_zero_c);
        cnt_next   = CntW'(MulStepsM);
        state_next = S_MUL_M;
      end
      S_MUL_M: begin
        hi_next  = mul_hi;
        lo_next  = mul_lo;
        cnt_next = cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          // product >> 24 lands exactly in the upper half
          mpt_next   = mul_hi[30:0];
          hi_next    = '0;
          lo_next    = LoW'(tmag);
          cnt_next   = CntW'(MulStepsE);
          state_next = S_MUL_E;
        end
      end
      S_MUL_E: begin
        hi_next  = mul_hi;
        lo_next  = mul_lo;
        cnt_next = cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          emag_next  = {mul_hi[30:0], mul_lo[LoW-1:16]};
          state_next = S_H1;
        end
      end
      S_H1: begin
        if (tneg || alu_co) begin
          habs_next  = alu_sum[47:0];
          hneg_next  = 1'b0;
          hi_next    = '0;
          lo_next    = cfg.gallons_per_mm;
          cnt_next   = CntW'(MulStepsG);
          state_next = S_MUL_G;
        end else begin
          state_next = S_H2;
        end
      end
      S_H2: begin
        habs_next  = alu_sum[47:0];
        hneg_next  = 1'b1;
        hi_next    = '0;
        lo_next    = cfg.gallons_per_mm;
        cnt_next   = CntW'(MulStepsG);
        state_next = S_MUL_G;
      end
      S_MUL_G: begin
        hi_next  = mul_hi;
        lo_next  = mul_lo;
        cnt_next = cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          state_next = S_RND;
        end
      end
      S_RND: begin
        gmag_next = alu_sum[64:24];
        if (cfg.max_height_mm == '0) begin
          state_next = S_DONE;
        end else begin
          hi_next    = '0;
          lo_next    = LoW'(PercentScale);
          cnt_next   = CntW'(MulStepsP);
          state_next = S_MUL_P;
        end
      end
      S_MUL_P: begin
        hi_next  = mul_hi;
        lo_next  = mul_lo;
        cnt_next = cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          // floor(|H|*100 / 2^24), then divide by the whole-mm maximum
          q_next     = {mul_hi[47:17], 31'd0};
          rem_next   = '0;
          cnt_next   = CntW'(Div2Steps);
          state_next = S_DIV2;
        end
      end
      S_DONE: begin
        if (res_take) begin
          relay_next = relay_new;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      relay <= 1'b0;
    end else begin
      state <= state_next;
      relay <= relay_next;
    end
  end

  always_ff @(posedge clk) begin
    q    <= q_next;
    rem  <= rem_next;
    root <= root_next;
    hi   <= hi_next;
    lo   <= lo_next;
    cnt  <= cnt_next;
    fac  <= fac_next;
    mpt  <= mpt_next;
    tmag <= tmag_next;
    tneg <= tneg_next;
    emag <= emag_next;
    habs <= habs_next;
    hneg <= hneg_next;
    gmag <= gmag_next;
  end

  assign status.idle  = (state == S_IDLE);
  assign status.done  = (state == S_DONE);
  assign status.relay = relay;

endmodule

### hw/rtl/echo_tank_level_relay_core.sv
`timescale 1ns / 1ps
`include "echo_tank_level_relay_core_defines.svh"

// Ultrasonic tank level relay. Each input transaction carries one echo
// period and the air temperature; one result transaction follows with the
// empty space, the volume in gallons, percent full and the relay drive.
// All work runs bit by bit through a single shared 65-bit adder: a 62-step
// restoring divide and a 31-step square root for the speed-of-sound factor,
// shift-add multiplies of 24, 16, 32 and 7 steps, and a 31-step divide for
// percent. The divide and root are skipped when the factor is fixed
// (absolute-zero register zero, or temperature at or below absolute zero)
// and the percent multiply and divide when the maximum height is zero; the
// extra state S_H2 runs when the echo distance exceeds the sensor height. The
// input is not ready while an item is in flight; a finished result waits in
// the output register, so the next item can be taken meanwhile. Config
// writes are accepted every cycle and must be made only while idle.
module echo_tank_level_relay_core
  import etl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t        cfg;
  eng_status_t status;
  out_item_t   res_item;
  logic        start;
  logic        load;

  assign cfg_ready = 1'b1;
  assign in_ready  = status.idle;
  assign start     = in_valid && in_ready;
  assign load      = status.done && (!out_valid || out_ready);

  etl_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  etl_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .in_item  (in_data),
    .cfg      (cfg),
    .res_take (load),
    .res_item (res_item),
    .status   (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res_item;
    end
  end

  `ETL_ASSERT_NEXT(a_busy_after_start, start, !in_ready, "input still ready after a transaction")
  `ETL_ASSERT_NEXT(a_result_lands, status.done && !out_valid, out_valid, "finished result not loaded")
  `ETL_ASSERT_NOW(a_relay_matches, out_valid, out_data.relay_on == status.relay, "relay state mismatch")

endmodule
